/* hw/rtl/kvs_pkg.sv */
// ----------------------------------------------------------------------------
// kvs_pkg: shared types and constants of the keyframe vec3 sampler
// Beat formats, key table row, sequencer states and table sizing.
// ----------------------------------------------------------------------------
package kvs_pkg;

    localparam int MAX_KEYS = 64;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;
    localparam int DAT_W    = 32;

    typedef struct packed {
        logic                    func;
        logic [IDX_W-1:0]        key_index;
        logic [DAT_W-1:0]        key_time;
        logic signed [DAT_W-1:0] key_x;
        logic signed [DAT_W-1:0] key_y;
        logic signed [DAT_W-1:0] key_z;
        logic [DAT_W-1:0]        sample_time;
    } t_in_beat;

    typedef struct packed {
        logic signed [DAT_W-1:0] out_x;
        logic signed [DAT_W-1:0] out_y;
        logic signed [DAT_W-1:0] out_z;
    } t_out_beat;

    typedef struct packed {
        logic [DAT_W-1:0] ktime;
        logic [DAT_W-1:0] kx;
        logic [DAT_W-1:0] ky;
        logic [DAT_W-1:0] kz;
    } t_key_row;

    typedef struct packed {
        logic start;
        logic done;
    } t_serial_ctl;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST_RD,
        S_FIRST_CHK,
        S_LAST_RD,
        S_LAST_CHK,
        S_SEG_RD,
        S_SEG_CHK,
        S_DIV,
        S_MUL,
        S_PUT
    } t_state;

endpackage

/* hw/rtl/kvs_key_mem.sv */
// ----------------------------------------------------------------------------
// kvs_key_mem: keyframe table
// One write port and one registered read port over rows of time and value.
// ----------------------------------------------------------------------------
module kvs_key_mem (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [kvs_pkg::IDX_W-1:0] i_waddr,
    input  kvs_pkg::t_key_row     i_wdata,
    input  logic [kvs_pkg::IDX_W-1:0] i_raddr,
    output kvs_pkg::t_key_row     o_rdata
);
    import kvs_pkg::*;

    t_key_row r_mem [MAX_KEYS];
    t_key_row r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/kvs_divider.sv */
// ----------------------------------------------------------------------------
// kvs_divider: bit-serial restoring divider
// Gives floor(num * 2^31 / den) for num <= den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kvs_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  kvs_pkg::t_serial_ctl       i_ctl,
    input  logic [kvs_pkg::DAT_W-1:0]  i_num,
    input  logic [kvs_pkg::DAT_W-1:0]  i_den,
    output logic                       o_done,
    output logic [kvs_pkg::DAT_W-1:0]  o_quo
);
    import kvs_pkg::*;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [4:0]       r_cnt, n_cnt;
    logic [DAT_W:0]   r_rem, n_rem;
    logic [DAT_W-1:0] r_quo, n_quo;
    logic [DAT_W-1:0] r_den, n_den;
    logic [DAT_W+1:0] w_diff;
    logic             w_bit;

    always_comb begin
        w_diff = {1'b0, r_rem} - {2'b00, r_den};
        w_bit  = ~w_diff[DAT_W+1];
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = {1'b0, i_num};
            n_den  = i_den;
        end else if (r_busy) begin
            // The remainder stays below the divisor, so the shifted value fits.
            n_rem = w_bit ? {w_diff[DAT_W-1:0], 1'b0} : {r_rem[DAT_W-1:0], 1'b0};
            n_quo = {r_quo[DAT_W-2:0], w_bit};
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* hw/rtl/kvs_blend_lane.sv */
// ----------------------------------------------------------------------------
// kvs_blend_lane: one component of the linear blend
// Shift-and-add product of (b - a) and the fraction, one fraction bit per
// cycle, then a + round(product / 2^31).
// ----------------------------------------------------------------------------
module kvs_blend_lane (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  kvs_pkg::t_serial_ctl              i_ctl,
    input  logic signed [kvs_pkg::DAT_W-1:0]  i_a,
    input  logic signed [kvs_pkg::DAT_W-1:0]  i_b,
    input  logic [kvs_pkg::DAT_W-1:0]         i_frac,
    output logic                              o_done,
    output logic signed [kvs_pkg::DAT_W-1:0]  o_res
);
    import kvs_pkg::*;

    localparam int ACC_W = 2*DAT_W + 2;

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic [4:0]              r_cnt, n_cnt;
    logic [DAT_W-1:0]        r_frac, n_frac;
    logic signed [DAT_W:0]   r_diff, n_diff;
    logic signed [DAT_W-1:0] r_a, n_a;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [ACC_W-1:0] w_rnd;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_frac = r_frac;
        n_diff = r_diff;
        n_a    = r_a;
        n_acc  = r_acc;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_frac = i_frac;
            n_a    = i_a;
            n_diff = {i_b[DAT_W-1], i_b} - {i_a[DAT_W-1], i_a};
            n_acc  = '0;
        end else if (r_busy) begin
            // Most significant fraction bit first.
            n_acc = (r_acc <<< 1)
                  + (r_frac[DAT_W-1] ? ACC_W'(r_diff) : ACC_W'(0));
            n_frac = {r_frac[DAT_W-2:0], 1'b0};
            n_cnt  = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_frac <= n_frac;
        r_diff <= n_diff;
        r_a    <= n_a;
        r_acc  <= n_acc;
    end

    // An arithmetic shift floors, which rounds half up once the half is added.
    assign w_rnd  = (r_acc + ACC_W'(64'sh4000_0000)) >>> 31;
    assign o_res  = r_a + w_rnd[DAT_W-1:0];
    assign o_done = r_done;

endmodule

/* hw/rtl/keyframe_vec3_sampler_unit.sv */
// ----------------------------------------------------------------------------
// keyframe_vec3_sampler_unit: keyframe table with linear vec3 sampling
// Stores keys, clamps at the ends and interpolates inside the first segment
// that holds the sample time.
//
//   channel | direction | handshake          | beat
//   in      | input     | valid / stall      | t_in_beat (key write or sample)
//   out     | output    | valid / stall      | t_out_beat (one per sample)
//   cfg     | input     | valid / ready      | key_count, 7 bits
//
// A key write does not stall the input. A sample stalls the input until its
// result moves to the output register: with no keys loaded it goes straight
// there, a clamp to the first key reads that key, and a clamp to the last reads
// the first and the last key. Interpolating reads one segment at a time through
// the single table read port, then runs the serial divider and the serial
// multipliers in turn. Reset is synchronous and clears key_count and the
// control state; table contents stay undefined until written. A stalled result
// is held in the output register while the next item may be accepted.
// ----------------------------------------------------------------------------
module keyframe_vec3_sampler_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  kvs_pkg::t_in_beat    i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output kvs_pkg::t_out_beat   o_out_beat,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [kvs_pkg::CNT_W-1:0] i_cfg_data
);
    import kvs_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_key_count;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_addr, n_addr;
    logic [DAT_W-1:0] r_t, n_t;
    t_key_row         r_prev, n_prev;
    t_key_row         r_cur, n_cur;
    logic [DAT_W-1:0] r_num, n_num;
    logic [DAT_W-1:0] r_len, n_len;
    t_out_beat        r_res, n_res;
    logic             r_out_valid, n_out_valid;
    t_out_beat        r_out, n_out;

    t_serial_ctl      w_div_ctl, w_mul_ctl;
    logic             w_div_done, w_mul_done, w_y_done, w_z_done;
    logic [DAT_W-1:0] w_quo, w_frac;
    logic signed [DAT_W-1:0] w_rx, w_ry, w_rz;
    logic             w_accept, w_we;
    t_key_row         w_wrow, w_rd;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_we     = w_accept && (i_in_beat.func == FUNC_WRITE);
    assign w_wrow   = '{ktime: i_in_beat.key_time, kx: i_in_beat.key_x,
                        ky: i_in_beat.key_y, kz: i_in_beat.key_z};

    kvs_key_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_in_beat.key_index),
        .i_wdata (w_wrow),
        .i_raddr (r_addr),
        .o_rdata (w_rd)
    );

    // A zero-length segment gives a zero fraction.
    assign w_frac = (r_len == '0) ? '0 : w_quo;

    // The divider loads its operands on the start edge, together with r_num and r_len.
    kvs_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (n_num),
        .i_den   (n_len),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    kvs_blend_lane u_lane_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (w_mul_ctl),
        .i_a (r_prev.kx), .i_b (r_cur.kx), .i_frac (w_frac),
        .o_done (w_mul_done), .o_res (w_rx)
    );

    kvs_blend_lane u_lane_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (w_mul_ctl),
        .i_a (r_prev.ky), .i_b (r_cur.ky), .i_frac (w_frac),
        .o_done (w_y_done), .o_res (w_ry)
    );

    kvs_blend_lane u_lane_z (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (w_mul_ctl),
        .i_a (r_prev.kz), .i_b (r_cur.kz), .i_frac (w_frac),
        .o_done (w_z_done), .o_res (w_rz)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_j         = r_j;
        n_addr      = r_addr;
        n_t         = r_t;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_num       = r_num;
        n_len       = r_len;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_div_ctl   = '{start: 1'b0, done: w_div_done};
        w_mul_ctl   = '{start: 1'b0, done: w_mul_done};
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_in_beat.func == FUNC_SAMPLE)) begin
                    n_t    = i_in_beat.sample_time;
                    n_n    = (r_key_count > CNT_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS)
                                                              : r_key_count;
                    n_addr = '0;
                    if (r_key_count == '0) begin
                        n_res   = '0;
                        n_state = S_PUT;
                    end else begin
                        n_state = S_FIRST_RD;
                    end
                end
            end
            S_FIRST_RD:  n_state = S_FIRST_CHK;
            S_FIRST_CHK: begin
                n_prev = w_rd;
                if (r_n == CNT_W'(1) || r_t <= w_rd.ktime) begin
                    n_res   = '{out_x: w_rd.kx, out_y: w_rd.ky, out_z: w_rd.kz};
                    n_state = S_PUT;
                end else begin
                    n_addr  = IDX_W'(r_n - CNT_W'(1));
                    n_state = S_LAST_RD;
                end
            end
            S_LAST_RD:   n_state = S_LAST_CHK;
            S_LAST_CHK: begin
                if (r_t >= w_rd.ktime) begin
                    n_res   = '{out_x: w_rd.kx, out_y: w_rd.ky, out_z: w_rd.kz};
                    n_state = S_PUT;
                end else begin
                    n_j     = CNT_W'(1);
                    n_addr  = IDX_W'(1);
                    n_state = S_SEG_RD;
                end
            end
            S_SEG_RD:    n_state = S_SEG_CHK;
            S_SEG_CHK: begin
                // The previous row holds key j-1; the row just read is key j.
                n_cur = w_rd;
                if (r_t >= r_prev.ktime && r_t <= w_rd.ktime) begin
                    n_num   = r_t - r_prev.ktime;
                    n_len   = w_rd.ktime - r_prev.ktime;
                    n_state = S_DIV;
                    w_div_ctl.start = 1'b1;
                end else if (r_j == r_n - CNT_W'(1)) begin
                    n_res   = '{out_x: w_rd.kx, out_y: w_rd.ky, out_z: w_rd.kz};
                    n_state = S_PUT;
                end else begin
                    n_prev  = w_rd;
                    n_j     = r_j + CNT_W'(1);
                    n_addr  = IDX_W'(r_j + CNT_W'(1));
                    n_state = S_SEG_RD;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    w_mul_ctl.start = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (w_mul_done) begin
                    n_res   = '{out_x: w_rx, out_y: w_ry, out_z: w_rz};
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_key_count <= i_cfg_data;
            end
        end
        r_n    <= n_n;
        r_j    <= n_j;
        r_addr <= n_addr;
        r_t    <= n_t;
        r_prev <= n_prev;
        r_cur  <= n_cur;
        r_num  <= n_num;
        r_len  <= n_len;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide phase");

    a_lanes_together: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done == w_y_done && w_mul_done == w_z_done)
        else $error("blend lanes out of step");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SEG_CHK |-> (r_j != '0 && r_j < r_n))
        else $error("segment scan index out of range");

    a_put_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT && !r_out_valid) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished result not moved to the output register");

endmodule

/* tb/sv/tb_keyframe_vec3_sampler_unit.sv */
// ----------------------------------------------------------------------------
// tb_keyframe_vec3_sampler_unit: self-checking bench for the keyframe sampler
// Loads key tables, sweeps key_count settings and sample times, predicts each
// sampled vec3 in the bench and compares every output beat in order.
// ----------------------------------------------------------------------------
module tb_keyframe_vec3_sampler_unit;
    import kvs_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_beat   i_in_beat = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_beat  o_out_beat;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data = '0;

    keyframe_vec3_sampler_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_beat(i_in_beat),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_beat(o_out_beat),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Bench copy of the key table and count.
    logic [DAT_W-1:0] key_times [MAX_KEYS];
    logic [DAT_W-1:0] key_xs [MAX_KEYS];
    logic [DAT_W-1:0] key_ys [MAX_KEYS];
    logic [DAT_W-1:0] key_zs [MAX_KEYS];
    int unsigned      keys_in_use = 0;
    t_out_beat        pending_samples [$];
    int               errors = 0;
    int               samples_checked = 0;
    int               beats_sent = 0;
    int               idle_cycles = 0;
    bit               long_hold = 1'b0;
    bit               burst_mode = 1'b1;

    function automatic logic [DAT_W-1:0] lerp_component(logic [DAT_W-1:0] a_bits,
            logic [DAT_W-1:0] b_bits, longint unsigned frac);
        longint a, diff, p, q;
        a    = longint'(signed'(a_bits));
        diff = longint'(signed'(b_bits)) - a;
        p    = diff * longint'(frac) + 64'sh4000_0000;
        if (p >= 0) q = p >>> 31;
        else q = -((longint'(-p) + 64'sh7FFF_FFFF) >>> 31);
        return DAT_W'(a + q);
    endfunction

    function automatic t_out_beat key_value(int k);
        t_out_beat r;
        r.out_x = key_xs[k];
        r.out_y = key_ys[k];
        r.out_z = key_zs[k];
        return r;
    endfunction

    function automatic t_out_beat sample_vec3(logic [DAT_W-1:0] t);
        int unsigned n;
        longint unsigned len, frac;
        t_out_beat r;
        n = (keys_in_use > MAX_KEYS) ? MAX_KEYS : keys_in_use;
        if (n == 0) return '0;
        if (n == 1 || t <= key_times[0]) return key_value(0);
        if (t >= key_times[n-1]) return key_value(n-1);
        for (int i = 0; i + 1 < n; i++) begin
            if (t >= key_times[i] && t <= key_times[i+1]) begin
                len  = key_times[i+1] - key_times[i];
                frac = 0;
                if (len != 0) frac = (longint'(t - key_times[i]) << 31) / len;
                r.out_x = lerp_component(key_xs[i], key_xs[i+1], frac);
                r.out_y = lerp_component(key_ys[i], key_ys[i+1], frac);
                r.out_z = lerp_component(key_zs[i], key_zs[i+1], frac);
                return r;
            end
        end
        return key_value(n-1);
    endfunction

    // Sends one beat, at times after a random gap unless in a burst. Valid stays
    // high after the beat so that the next beat can follow straight on.
    task automatic send_beat(t_in_beat b);
        if (!burst_mode && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_beat  <= b;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        beats_sent++;
        if (b.func == FUNC_WRITE) begin
            key_times[b.key_index] = b.key_time;
            key_xs[b.key_index]    = b.key_x;
            key_ys[b.key_index]    = b.key_y;
            key_zs[b.key_index]    = b.key_z;
        end else begin
            pending_samples.push_back(sample_vec3(b.sample_time));
        end
        @(negedge i_clk);
        if ($urandom_range(0, 7) == 0) burst_mode = !burst_mode;
    endtask

    task automatic write_key(int idx, logic [DAT_W-1:0] t, logic [DAT_W-1:0] x,
            logic [DAT_W-1:0] y, logic [DAT_W-1:0] z);
        t_in_beat b;
        b = '0;
        b.func = FUNC_WRITE; b.key_index = IDX_W'(idx); b.key_time = t;
        b.key_x = x; b.key_y = y; b.key_z = z;
        b.sample_time = $urandom;
        send_beat(b);
    endtask

    task automatic sample_at(logic [DAT_W-1:0] t);
        t_in_beat b;
        b = '0;
        b.func = FUNC_SAMPLE; b.sample_time = t;
        b.key_index = IDX_W'($urandom); b.key_time = $urandom;
        b.key_x = $urandom; b.key_y = $urandom; b.key_z = $urandom;
        send_beat(b);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    // Only called when idle; keys up to the count must be loaded before sampling.
    task automatic set_key_count(int unsigned n);
        drain();
        i_cfg_data  <= CNT_W'(n);
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        keys_in_use = n;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Loads n sorted keys, sometimes with repeated times for zero-length segments.
    task automatic load_sorted(int n, int unsigned max_step);
        logic [DAT_W-1:0] t;
        t = $urandom_range(0, 1000);
        for (int i = 0; i < n; i++) begin
            write_key(i, t, $urandom, $urandom, $urandom);
            if ($urandom_range(0, 9) != 0) t = t + $urandom_range(1, max_step);
        end
    endtask

    function automatic logic [DAT_W-1:0] pick_time(int n);
        int unsigned lim;
        lim = (n < 1) ? 1 : n;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return key_times[$urandom_range(0, lim - 1)];
            default: return key_times[0] + $urandom_range(0,
                           key_times[lim-1] - key_times[0] + 2);
        endcase
    endfunction

    task automatic test_directed();
        set_key_count(0);
        sample_at(32'h0);
        sample_at(32'hFFFF_FFFF);
        write_key(0, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        write_key(1, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        write_key(2, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
        write_key(63, 32'h8000_0000, 32'h1234_5678, 32'hFEDC_BA98, 32'h0);
        set_key_count(1);
        sample_at(32'h0);
        sample_at(32'hFFFF_FFFF);
        set_key_count(3);
        sample_at(32'h0001_0000);
        sample_at(32'h0);
        sample_at(32'hFFFF_FFFF);
        sample_at(32'h8000_0000);
        sample_at(32'hFFFF_FFFE);
        // Unsorted keys: slot 3 lies before slot 2.
        write_key(3, 32'h0000_8000, 32'h1, 32'h2, 32'h3);
        set_key_count(4);
        sample_at(32'h0000_C000);
        sample_at(32'h0002_0000);
        for (int i = 4; i < MAX_KEYS; i++) write_key(i, 32'hFFFF_FFFF, i, -i, i * 3);
        // Counts above the table size are clipped to it.
        set_key_count(127);
        sample_at(32'h9000_0000);
        set_key_count(65);
        sample_at(32'h0000_0001);
    endtask

    task automatic test_random_tables(int rounds);
        int n;
        for (int r = 0; r < rounds; r++) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 64) : $urandom_range(2, 8);
            drain();
            load_sorted(n, ($urandom_range(0, 1) != 0) ? 32'h0010_0000 : 32'h1000_0000);
            set_key_count(n);
            repeat ($urandom_range(5, 14)) begin
                if ($urandom_range(0, 9) == 0)
                    // Rewrite a loaded key with the same time to keep the order.
                    begin
                        int k;
                        k = $urandom_range(0, n - 1);
                        write_key(k, key_times[k], $urandom, $urandom, $urandom);
                    end
                else
                    sample_at(pick_time(n));
            end
        end
    endtask

    task automatic test_backpressure();
        int n;
        n = 4;
        load_sorted(n, 32'h0100_0000);
        set_key_count(n);
        long_hold = 1'b1;
        burst_mode = 1'b1;
        repeat (8) sample_at(pick_time(n));
        long_hold = 1'b0;
        // Sender pauses until every result has come.
        drain();
        repeat (6) sample_at(pick_time(n));
    endtask

    // Receiver stall pattern, with a long hold when requested.
    initial begin
        int hold;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_out_stall <= 1'b1;
                for (hold = 0; hold < 600 && long_hold; hold++) @(negedge i_clk);
                i_out_stall <= 1'b0;
                while (long_hold) @(negedge i_clk);
            end else if ($urandom_range(0, 63) < 4) begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(20, 60)) @(negedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_samples.size() == 0) begin
                $display("%0t: output beat with nothing expected: %h", $realtime, o_out_beat);
                errors++;
            end else begin
                t_out_beat want;
                want = pending_samples.pop_front();
                if (o_out_beat.out_x !== want.out_x) begin
                    $display("%0t: out_x expected %h got %h", $realtime, want.out_x,
                             o_out_beat.out_x);
                    errors++;
                end
                if (o_out_beat.out_y !== want.out_y) begin
                    $display("%0t: out_y expected %h got %h", $realtime, want.out_y,
                             o_out_beat.out_y);
                    errors++;
                end
                if (o_out_beat.out_z !== want.out_z) begin
                    $display("%0t: out_z expected %h got %h", $realtime, want.out_z,
                             o_out_beat.out_z);
                    errors++;
                end
                samples_checked++;
            end
        end
    end

    // Watchdog on cycles with no beat moving on any channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_backpressure();
        test_random_tables(65);
        drain();
        repeat (300) @(negedge i_clk);
        if (pending_samples.size() != 0) begin
            $display("%0t: %0d expected samples never arrived", $realtime,
                     pending_samples.size());
            errors++;
        end
        $display("Covered %0d input beats and %0d checked samples over clamps,", beats_sent,
                 samples_checked);
        $display("interpolation, empty and clipped counts, unsorted keys and back-pressure.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
